>>> rtl/core/assert_macros.svh
// assertion macros for the allocator rtl
// no dependencies; disabled by defining NO_ASSERTIONS
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/ffha_pkg.sv
// constants, block table entry type and status codes for the heap allocator
// no dependencies
package ffha_pkg;
   localparam int HEAP_BYTES   = 1048576;
   localparam int HEADER_BYTES = 16;
   localparam int MAX_BLOCKS   = 64;
   localparam int GRAIN        = 8;
   localparam int OFF_W        = 20;
   localparam int SIZE_W       = 21;
   localparam int NEED_W       = SIZE_W + 1;
   localparam int IDX_W        = $clog2(MAX_BLOCKS);
   localparam int CNT_W        = IDX_W + 1;
   localparam int REQ_DATA_W   = 48;
   localparam int RSP_DATA_W   = 24;

   localparam logic       OP_ALLOC = 1'b0;
   localparam logic       OP_FREE  = 1'b1;

   localparam logic [1:0] STAT_DONE     = 2'd0;
   localparam logic [1:0] STAT_NOOP     = 2'd1;
   localparam logic [1:0] STAT_NO_SPACE = 2'd2;
   localparam logic [1:0] STAT_BAD_FREE = 2'd3;

   typedef struct packed {
      logic [OFF_W-1:0] start;
      logic [OFF_W-1:0] len;
      logic             free;
   } entry_type;
endpackage

>>> rtl/core/first_fit_heap_allocator_unit.sv
// first-fit heap allocator with coalescing, block table kept in a local memory
// depends on ffha_pkg and assert_macros.svh
// each table entry scanned is read and then checked, plus each entry shifted on split or merge
// is read and then written; one request at a time, bounded by the single read port of the
// block table. a zero size or null address answers with the no-op status without a table scan.
// reset: synchronous; after reset the init state writes the initial free block, then ready.
`include "assert_macros.svh"
module first_fit_heap_allocator_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // size [20:0], addr [40:21], zero fill
   input  logic [ffha_pkg::REQ_DATA_W-1:0] req_tdata,
   // type [0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status [1:0], user_offset [21:2], zero fill
   output logic [ffha_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ffha_pkg::*;

   typedef enum logic [11:0] {
      ST_INIT     = 12'b000000000001,
      ST_IDLE     = 12'b000000000010,
      ST_SCAN_RD  = 12'b000000000100,
      ST_SCAN_CHK = 12'b000000001000,
      ST_SHIFT_RD = 12'b000000010000,
      ST_SHIFT_WR = 12'b000000100000,
      ST_INS      = 12'b000001000000,
      ST_PUT      = 12'b000010000000,
      ST_NEXT_RD  = 12'b000100000000,
      ST_NEXT_CHK = 12'b001000000000,
      ST_PREV_RD  = 12'b010000000000,
      ST_PREV_CHK = 12'b100000000000
   } state_type;

   localparam logic [OFF_W-1:0] HDR    = OFF_W'(HEADER_BYTES);
   localparam logic [CNT_W-1:0] MAXCNT = CNT_W'(MAX_BLOCKS);

   entry_type mem [MAX_BLOCKS];
   entry_type rd_ff;
   logic [IDX_W-1:0] raddr;
   logic             we;
   logic [IDX_W-1:0] waddr;
   entry_type        wdata;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic              op_ff, op_in;
   logic [OFF_W-1:0]  addr_ff, addr_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [CNT_W-1:0]  total_ff, total_in, idx_ff, idx_in, pos_ff, pos_in, k_ff, k_in;
   logic              up_ff, up_in;
   entry_type         cur_ff, cur_in, ins_ff, ins_in;
   logic [1:0]        status_ff, status_in;
   logic [OFF_W-1:0]  offset_ff, offset_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              pend_ff, pend_in;

   logic [SIZE_W-1:0] req_size;
   logic [OFF_W-1:0]  req_addr;
   logic              req_fire;

   assign req_size   = req_tdata[SIZE_W-1:0];
   assign req_addr   = req_tdata[SIZE_W+OFF_W-1:SIZE_W];
   assign req_tready = (state_ff == ST_IDLE) && !pend_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      need_in      = need_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      up_in        = up_ff;
      cur_in       = cur_ff;
      ins_in       = ins_ff;
      status_in    = status_ff;
      offset_in    = offset_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      raddr        = idx_ff[IDX_W-1:0];
      we           = 1'b0;
      waddr        = pos_ff[IDX_W-1:0];
      wdata        = cur_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      // a finished result moves into the output word once it is free
      if (pend_ff && (!rsp_valid_ff || rsp_tready)) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_DATA_W - OFF_W - 2){1'b0}}, offset_ff, status_ff};
      end

      case (state_ff)
         ST_INIT: begin
            we       = 1'b1;
            waddr    = '0;
            wdata    = '{start: '0, len: OFF_W'(HEAP_BYTES - HEADER_BYTES), free: 1'b1};
            total_in = CNT_W'(1);
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               op_in     = req_tuser;
               addr_in   = req_addr;
               need_in   = ({1'b0, req_size} + NEED_W'(GRAIN - 1)) & ~NEED_W'(GRAIN - 1);
               idx_in    = '0;
               status_in = STAT_DONE;
               offset_in = '0;
               if ((req_tuser == OP_ALLOC && req_size == '0) ||
                   (req_tuser == OP_FREE && req_addr == '0)) begin
                  status_in = STAT_NOOP;
                  pend_in   = 1'b1;
               end else begin
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            raddr = idx_ff[IDX_W-1:0];
            if (idx_ff == total_ff) begin
               status_in = (op_ff == OP_ALLOC) ? STAT_NO_SPACE : STAT_BAD_FREE;
               pend_in   = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            idx_in   = idx_ff + CNT_W'(1);
            state_in = ST_SCAN_RD;
            pos_in   = idx_ff;
            if (op_ff == OP_ALLOC) begin
               if (rd_ff.free && {{(NEED_W-OFF_W){1'b0}}, rd_ff.len} >= need_ff) begin
                  cur_in      = rd_ff;
                  cur_in.free = 1'b0;
                  if ({3'b0, rd_ff.len} >= {1'b0, need_ff} + (NEED_W+1)'(HEADER_BYTES + GRAIN)
                      && total_ff < MAXCNT) begin
                     cur_in.len   = need_ff[OFF_W-1:0];
                     ins_in.start = rd_ff.start + HDR + need_ff[OFF_W-1:0];
                     ins_in.len   = rd_ff.len - need_ff[OFF_W-1:0] - HDR;
                     ins_in.free  = 1'b1;
                     k_in         = total_ff;
                     up_in        = 1'b1;
                     ret_in       = ST_INS;
                     state_in     = ST_SHIFT_RD;
                  end else begin
                     state_in = ST_PUT;
                  end
               end
            end else begin
               if (!rd_ff.free && ({1'b0, rd_ff.start} + {1'b0, HDR}) == {1'b0, addr_ff}) begin
                  cur_in      = rd_ff;
                  cur_in.free = 1'b1;
                  state_in    = ST_NEXT_RD;
               end
            end
         end
         ST_SHIFT_RD: begin
            if (up_ff) begin
               raddr = k_ff[IDX_W-1:0] - IDX_W'(1);
               if (k_ff <= pos_ff + CNT_W'(1)) begin
                  state_in = ret_ff;
               end else begin
                  state_in = ST_SHIFT_WR;
               end
            end else begin
               raddr = k_ff[IDX_W-1:0] + IDX_W'(1);
               if (k_ff + CNT_W'(1) >= total_ff) begin
                  total_in = total_ff - CNT_W'(1);
                  state_in = ret_ff;
               end else begin
                  state_in = ST_SHIFT_WR;
               end
            end
         end
         ST_SHIFT_WR: begin
            we       = 1'b1;
            waddr    = k_ff[IDX_W-1:0];
            wdata    = rd_ff;
            k_in     = up_ff ? k_ff - CNT_W'(1) : k_ff + CNT_W'(1);
            state_in = ST_SHIFT_RD;
         end
         ST_INS: begin
            we       = 1'b1;
            waddr    = pos_ff[IDX_W-1:0] + IDX_W'(1);
            wdata    = ins_ff;
            total_in = total_ff + CNT_W'(1);
            state_in = ST_PUT;
         end
         ST_PUT: begin
            we = 1'b1;
            if (op_ff == OP_ALLOC) begin
               offset_in = cur_ff.start + HDR;
               pend_in   = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_PREV_RD;
            end
         end
         ST_NEXT_RD: begin
            raddr = pos_ff[IDX_W-1:0] + IDX_W'(1);
            if (pos_ff + CNT_W'(1) < total_ff) begin
               state_in = ST_NEXT_CHK;
            end else begin
               state_in = ST_PUT;
            end
         end
         ST_NEXT_CHK: begin
            if (rd_ff.free) begin
               cur_in.len = cur_ff.len + HDR + rd_ff.len;
               k_in       = pos_ff + CNT_W'(1);
               up_in      = 1'b0;
               ret_in     = ST_NEXT_RD;
               state_in   = ST_SHIFT_RD;
            end else begin
               state_in = ST_PUT;
            end
         end
         ST_PREV_RD: begin
            raddr = pos_ff[IDX_W-1:0] - IDX_W'(1);
            if (pos_ff != '0) begin
               state_in = ST_PREV_CHK;
            end else begin
               pend_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_PREV_CHK: begin
            if (rd_ff.free) begin
               we        = 1'b1;
               waddr     = pos_ff[IDX_W-1:0] - IDX_W'(1);
               wdata     = rd_ff;
               wdata.len = rd_ff.len + HDR + cur_ff.len;
               k_in      = pos_ff;
               up_in     = 1'b0;
               ret_in    = ST_IDLE;
               pend_in   = 1'b1;
               state_in  = ST_SHIFT_RD;
            end else begin
               pend_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         ret_ff       <= ST_IDLE;
         total_ff     <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      need_ff     <= need_in;
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      k_ff        <= k_in;
      up_ff       <= up_in;
      cur_ff      <= cur_in;
      ins_ff      <= ins_in;
      status_ff   <= status_in;
      offset_ff   <= offset_in;
      rsp_data_ff <= rsp_data_in;
   end

   `ASSERT_ALWAYS(a_total_range, clock, reset, total_ff != '0 && total_ff <= MAXCNT)
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire && !(op_in == OP_ALLOC && need_in == '0) && !(op_in == OP_FREE && addr_in == '0), state_ff != ST_IDLE)
   `ASSERT_IMPLY(a_rsp_from_pending, clock, reset, $rose(rsp_valid_ff), $past(pend_ff))
endmodule
